[design/fspc_pkg.sv]
// fspc_pkg: opcodes, instruction field helpers and the forwarding function
// shared by the five-stage core
// depends on: nothing
`timescale 1ns / 1ps
package fspc_pkg;

  localparam int REG_COUNT = 8;
  localparam logic [31:0] NOOP_WORD = 32'h01c0_0000;
  localparam logic [11:0] PC_MASK = 12'hfff;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_NAND = 3'd1;
  localparam logic [2:0] OP_LW   = 3'd2;
  localparam logic [2:0] OP_SW   = 3'd3;
  localparam logic [2:0] OP_BEQ  = 3'd4;
  localparam logic [2:0] OP_HALT = 3'd6;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } dest_t;

  function automatic logic [2:0] opc(input logic [31:0] w);
    return w[24:22];
  endfunction

  function automatic logic [2:0] fld_a(input logic [31:0] w);
    return w[21:19];
  endfunction

  function automatic logic [2:0] fld_b(input logic [31:0] w);
    return w[18:16];
  endfunction

  // destination of a register writer (a load only when allow_load is set), hit low for anything else
  function automatic dest_t dest_of(input logic [31:0] w, input logic allow_load);
    dest_t d;
    d.hit = 1'b0;
    d.idx = 3'd0;
    if (opc(w) == OP_ADD || opc(w) == OP_NAND) begin
      d.hit = 1'b1;
      d.idx = w[2:0];
    end else if (opc(w) == OP_LW && allow_load) begin
      d.hit = 1'b1;
      d.idx = fld_a(w);
    end
    return d;
  endfunction

  // operand forwarding, nearest writer first
  function automatic logic [31:0] fwd(input logic [2:0] r, input logic [31:0] fallback,
                                      input logic [31:0] exmem, input logic [31:0] memwb,
                                      input logic [31:0] wbend, input logic [31:0] alu,
                                      input logic [31:0] wb0, input logic [31:0] wb1);
    dest_t d0;
    dest_t d1;
    dest_t d2;
    d0 = dest_of(exmem, 1'b0);
    d1 = dest_of(memwb, 1'b1);
    d2 = dest_of(wbend, 1'b1);
    if (d0.hit && d0.idx == r) return alu;
    if (d1.hit && d1.idx == r) return wb0;
    if (d2.hit && d2.idx == r) return wb1;
    return fallback;
  endfunction

endpackage

[design/five_stage_pipeline_core_unit.sv]
// five-stage core: fetch/decode/execute/memory/writeback with forwarding,
// a load-use interlock and branch flush; results are registered, one
// transaction per cycle while in_stall is low. Instruction, data and register
// stores are synchronous memories read ahead with write bypass. After reset
// a clearing pass over all MEM_WORDS words zeroes the data store and in_stall
// stays high meanwhile. depends on: fspc_pkg. MEM_WORDS must be a power of two.
`timescale 1ns / 1ps
module five_stage_pipeline_core_unit
  import fspc_pkg::*;
#(
  parameter int MEM_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [11:0] in_load_address,
  input  logic signed [31:0] in_load_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_pc_now,
  output logic        out_halted,
  output logic [31:0] out_cycle_count,
  output logic [31:0] out_retire_total,
  output logic [31:0] out_branch_count,
  output logic [31:0] out_taken_count
);

  localparam int AW = $clog2(MEM_WORDS);

  // pipeline state
  logic [11:0] pc_r, pc_nxt;
  logic [31:0] ifid_r, ifid_nxt, idex_r, idex_nxt, exmem_r, exmem_nxt;
  logic [31:0] memwb_r, wbend_r;
  logic        ifid_v_r, ifid_v_nxt, idex_v_r, idex_v_nxt, exmem_v_r, exmem_v_nxt;
  logic        memwb_v_r;
  logic [11:0] ifid_pc_r, ifid_pc_nxt, idex_pc_r, idex_pc_nxt;
  logic [31:0] opa_r, opa_nxt, opb_r, opb_nxt;
  logic [15:0] off_r, off_nxt;
  logic [31:0] alu_r, alu_nxt, store_r, store_nxt;
  logic [11:0] tgt_r, tgt_nxt;
  logic [31:0] wb0_r, wb0_nxt, wb1_r;
  logic [31:0] cyc_r, cyc_nxt, ret_r, ret_nxt, brn_r, brn_nxt, tkn_r, tkn_nxt;
  logic        halt_r, halt_nxt;

  // handshake
  logic out_valid_r;
  logic clr_r;
  logic [AW-1:0] clr_cnt_r;
  logic acc, tick_go, load_go;

  assign in_stall = clr_r || (out_valid_r && out_stall);
  assign acc      = in_valid && !in_stall;
  assign tick_go  = acc && in_kind && !halt_r;
  assign load_go  = acc && !in_kind;

  // memories
  logic [31:0] imem [MEM_WORDS];
  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] rf   [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;

  logic [31:0] pc_ext, ld_ext;
  logic [AW-1:0] im_ra, ld_idx, dm_ra, dm_wa;
  logic [31:0] dm_wd;
  logic        dm_we;
  logic [31:0] im_q_r, im_bw_r, dm_q_r, dm_bw_r, rf_qa_r, rf_qb_r, rf_bw_r;
  logic        im_byp_r, dm_byp_r, rfa_byp_r, rfb_byp_r, rfa_v_r, rfb_v_r;
  logic [2:0]  rf_ra, rf_rb, rf_wa;
  logic        rf_we;
  logic [31:0] fetched, dm_rd, rf_a_val, rf_b_val;

  assign pc_ext = 32'(pc_nxt);
  assign ld_ext = 32'(in_load_address);
  assign im_ra  = pc_ext[AW-1:0];
  assign ld_idx = ld_ext[AW-1:0];
  assign dm_ra  = alu_nxt[AW-1:0];
  assign rf_ra  = fld_a(ifid_nxt);
  assign rf_rb  = fld_b(ifid_nxt);

  assign fetched  = im_byp_r ? im_bw_r : im_q_r;
  assign dm_rd    = dm_byp_r ? dm_bw_r : dm_q_r;
  assign rf_a_val = rfa_byp_r ? rf_bw_r : (rfa_v_r ? rf_qa_r : 32'd0);
  assign rf_b_val = rfb_byp_r ? rf_bw_r : (rfb_v_r ? rf_qb_r : 32'd0);

  // data store write port: clearing pass, load, then store word
  always_comb begin
    dm_we = 1'b0;
    dm_wa = alu_r[AW-1:0];
    dm_wd = store_r;
    if (clr_r) begin
      dm_we = 1'b1;
      dm_wa = clr_cnt_r;
      dm_wd = 32'd0;
    end else if (load_go) begin
      dm_we = 1'b1;
      dm_wa = ld_idx;
      dm_wd = in_load_word;
    end else if (tick_go && opc(exmem_r) == OP_SW) begin
      dm_we = 1'b1;
    end
  end

  // instruction store, read ahead at the next pc
  always_ff @(posedge clk) begin
    if (load_go) begin
      imem[ld_idx] <= in_load_word;
    end
    im_q_r   <= imem[im_ra];
    im_byp_r <= load_go && (ld_idx == im_ra);
    im_bw_r  <= in_load_word;
  end

  // data store, read ahead at the next alu result
  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_wa] <= dm_wd;
    end
    dm_q_r   <= dmem[dm_ra];
    dm_byp_r <= dm_we && (dm_wa == dm_ra);
    dm_bw_r  <= dm_wd;
  end

  // register file, read ahead at the next decode fields
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_wa] <= wb0_r;
    end
    rf_qa_r   <= rf[rf_ra];
    rf_qb_r   <= rf[rf_rb];
    rfa_byp_r <= rf_we && (rf_wa == rf_ra);
    rfb_byp_r <= rf_we && (rf_wa == rf_rb);
    rf_bw_r   <= wb0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      rfa_v_r  <= 1'b0;
      rfb_v_r  <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_r[rf_wa] <= 1'b1;
      end
      rfa_v_r <= rf_vld_r[rf_ra];
      rfb_v_r <= rf_vld_r[rf_rb];
    end
  end

  // hazard and writeback decode
  dest_t wb_dest;
  logic  ld_use, br_taken;
  logic [31:0] a_op, b_op, off32;

  assign wb_dest = dest_of(memwb_r, 1'b1);
  assign rf_we   = tick_go && wb_dest.hit;
  assign rf_wa   = wb_dest.idx;
  assign ld_use  = (opc(idex_r) <= OP_BEQ) && (opc(exmem_r) == OP_LW) &&
                   (fld_a(exmem_r) == fld_a(idex_r) || fld_a(exmem_r) == fld_b(idex_r));
  assign br_taken = (opc(exmem_r) == OP_BEQ) && (alu_r == 32'd0);
  assign off32   = {{16{off_r[15]}}, off_r};
  assign a_op    = fwd(fld_a(idex_r), opa_r, exmem_r, memwb_r, wbend_r, alu_r, wb0_r, wb1_r);
  assign b_op    = fwd(fld_b(idex_r), opb_r, exmem_r, memwb_r, wbend_r, alu_r, wb0_r, wb1_r);

  // next state for one clock of the core
  always_comb begin
    pc_nxt = pc_r;
    ifid_nxt = ifid_r; ifid_v_nxt = ifid_v_r; ifid_pc_nxt = ifid_pc_r;
    idex_nxt = idex_r; idex_v_nxt = idex_v_r; idex_pc_nxt = idex_pc_r;
    opa_nxt = opa_r; opb_nxt = opb_r; off_nxt = off_r;
    exmem_nxt = exmem_r; exmem_v_nxt = exmem_v_r;
    alu_nxt = alu_r; tgt_nxt = tgt_r; store_nxt = store_r;
    wb0_nxt = wb0_r;
    cyc_nxt = cyc_r; ret_nxt = ret_r; brn_nxt = brn_r; tkn_nxt = tkn_r;
    halt_nxt = halt_r;
    if (tick_go) begin
      // fetch and decode
      pc_nxt = pc_r + 12'd1;
      ifid_nxt = fetched; ifid_v_nxt = 1'b1; ifid_pc_nxt = pc_r + 12'd1;
      idex_nxt = ifid_r; idex_v_nxt = ifid_v_r; idex_pc_nxt = ifid_pc_r;
      opa_nxt = rf_a_val; opb_nxt = rf_b_val; off_nxt = ifid_r[15:0];
      // execute
      exmem_nxt = idex_r; exmem_v_nxt = idex_v_r;
      alu_nxt = 32'd0; tgt_nxt = 12'd0; store_nxt = a_op;
      case (opc(idex_r))
        OP_ADD:  alu_nxt = a_op + b_op;
        OP_NAND: alu_nxt = ~(a_op & b_op);
        OP_LW,
        OP_SW:   alu_nxt = b_op + off32;
        OP_BEQ: begin
          alu_nxt = a_op - b_op;
          tgt_nxt = off32[11:0] + idex_pc_r;
        end
        default: alu_nxt = 32'd0;
      endcase
      if (ld_use) begin
        exmem_nxt = NOOP_WORD; exmem_v_nxt = 1'b0;
        alu_nxt = 32'd0; tgt_nxt = 12'd0; store_nxt = 32'd0;
        pc_nxt = pc_r;
        ifid_nxt = ifid_r; ifid_v_nxt = ifid_v_r; ifid_pc_nxt = ifid_pc_r;
        idex_nxt = idex_r; idex_v_nxt = idex_v_r; idex_pc_nxt = idex_pc_r;
        opa_nxt = opa_r; opb_nxt = opb_r; off_nxt = off_r;
      end
      // memory
      wb0_nxt = alu_r;
      if (opc(exmem_r) == OP_LW) begin
        wb0_nxt = dm_rd;
      end else if (opc(exmem_r) == OP_BEQ) begin
        wb0_nxt = 32'd0;
        brn_nxt = brn_r + 32'd1;
        if (br_taken) begin
          tkn_nxt = tkn_r + 32'd1;
          pc_nxt = tgt_r & PC_MASK;
          ifid_nxt = NOOP_WORD; ifid_v_nxt = 1'b0; ifid_pc_nxt = 12'd0;
          idex_nxt = NOOP_WORD; idex_v_nxt = 1'b0; idex_pc_nxt = 12'd0;
          opa_nxt = 32'd0; opb_nxt = 32'd0; off_nxt = 16'd0;
          exmem_nxt = NOOP_WORD; exmem_v_nxt = 1'b0;
          alu_nxt = 32'd0; tgt_nxt = 12'd0; store_nxt = 32'd0;
        end
      end
      // writeback statistics
      if (memwb_v_r) begin
        ret_nxt = ret_r + 32'd1;
      end
      cyc_nxt  = cyc_r + 32'd1;
      halt_nxt = (opc(exmem_r) == OP_HALT);
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      ifid_r <= NOOP_WORD; idex_r <= NOOP_WORD; exmem_r <= NOOP_WORD;
      memwb_r <= NOOP_WORD; wbend_r <= NOOP_WORD;
      ifid_v_r <= 1'b0; idex_v_r <= 1'b0; exmem_v_r <= 1'b0;
      memwb_v_r <= 1'b0;
      ifid_pc_r <= '0; idex_pc_r <= '0;
      opa_r <= '0; opb_r <= '0; off_r <= '0;
      alu_r <= '0; tgt_r <= '0; store_r <= '0;
      wb0_r <= '0; wb1_r <= '0;
      cyc_r <= '0; ret_r <= '0; brn_r <= '0; tkn_r <= '0;
      halt_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      ifid_r <= ifid_nxt; ifid_v_r <= ifid_v_nxt; ifid_pc_r <= ifid_pc_nxt;
      idex_r <= idex_nxt; idex_v_r <= idex_v_nxt; idex_pc_r <= idex_pc_nxt;
      opa_r <= opa_nxt; opb_r <= opb_nxt; off_r <= off_nxt;
      exmem_r <= exmem_nxt; exmem_v_r <= exmem_v_nxt;
      alu_r <= alu_nxt; tgt_r <= tgt_nxt; store_r <= store_nxt;
      if (tick_go) begin
        memwb_r <= exmem_r; memwb_v_r <= exmem_v_r;
        wbend_r <= memwb_r;
        wb1_r <= wb0_r;
      end
      wb0_r <= wb0_nxt;
      cyc_r <= cyc_nxt; ret_r <= ret_nxt; brn_r <= brn_nxt; tkn_r <= tkn_nxt;
      halt_r <= halt_nxt;
    end
  end

  // clearing pass over the data store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_pc_now        <= pc_nxt;
      out_halted        <= halt_nxt;
      out_cycle_count   <= cyc_nxt;
      out_retire_total  <= ret_nxt;
      out_branch_count  <= brn_nxt;
      out_taken_count   <= tkn_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a taken branch empties the three younger stages
  a_br_flush: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go && br_taken |=> !ifid_v_r && !idex_v_r && !exmem_v_r)
    else $error("taken branch did not flush");

  // a load-use interlock without a taken branch holds the pc
  a_ld_use_hold: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go && ld_use && !br_taken |=> pc_r == $past(pc_r) && !exmem_v_r)
    else $error("load-use interlock did not hold fetch");

  // once halted the core stays halted
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag dropped");

  // no transaction while the data store is being cleared
  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !acc && !rf_we)
    else $error("transaction during clearing pass");

endmodule
